// ===== src/cbpw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped blend pixel writer package
// Shared widths, register and mode codes, and the channel mix function.
// ----------------------------------------------------------------------------
package cbpw_pkg;

  localparam int COORD_BITS     = 12;
  localparam int SPAN_BITS      = COORD_BITS + 1;
  localparam int CFG_DATA_BITS  = SPAN_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COLOR_BITS     = 32;
  localparam int CHAN_BITS      = 8;

  localparam logic [SPAN_BITS-1:0] SPAN_FULL = {1'b1, {COORD_BITS{1'b0}}};
  localparam logic [CHAN_BITS-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    MODE_OPAQUE = 2'd0,
    MODE_CONST  = 2'd1,
    MODE_SRC    = 2'd2
  } blend_mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLIP_LEFT      = 3'd0,
    REG_CLIP_TOP       = 3'd1,
    REG_CLIP_WIDTH     = 3'd2,
    REG_CLIP_HEIGHT    = 3'd3,
    REG_BLEND_MODE     = 3'd4,
    REG_CONSTANT_ALPHA = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                  take;
    logic [COLOR_BITS-1:0] color;
  } blend_res_t;

  // (s*a + d*(255-a)) / 255, the divide done as a shift-and-add that is exact
  // for every sum two 8-bit products can reach.
  function automatic logic [CHAN_BITS-1:0] mix_channel(
    input logic [CHAN_BITS-1:0] s,
    input logic [CHAN_BITS-1:0] d,
    input logic [CHAN_BITS-1:0] a
  );
    logic [2*CHAN_BITS-1:0] sum;
    logic [2*CHAN_BITS:0]   adj;
    sum = ({8'h00, s} * {8'h00, a}) + ({8'h00, d} * {8'h00, ALPHA_OPAQUE - a});
    adj = {1'b0, sum} + {9'h000, sum[15:8]} + 17'd1;
    return adj[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== src/clipped_blend_pixel_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped blend pixel writer
// Clips a pixel write, blends it, writes only on change, tracks a dirty box.
// ----------------------------------------------------------------------------
//  Port group | Handshake              | Carries
//  in_*       | in_valid / in_ready    | opcode, pixel_x, pixel_y, colors
//  out_*      | out_valid / out_ready  | write_enable, write_color, dirty box
//  cfg_*      | cfg_wr_en              | cfg_index selects, cfg_data value
//
//  One item per clock sustained while out_ready stays high; each item is held in
//  the input register, then in the result register, where it appears at the output.
//  The dirty box is updated as an item moves into the result register, so the
//  next item already sees it.
//  Reset is synchronous: clears both valid stages, the box and the configuration registers.
//  With out_ready low the result holds and the input stage still takes one item.
// ----------------------------------------------------------------------------
module clipped_blend_pixel_writer (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_opcode,
  input  wire [cbpw_pkg::COORD_BITS-1:0]       in_pixel_x,
  input  wire [cbpw_pkg::COORD_BITS-1:0]       in_pixel_y,
  input  wire [cbpw_pkg::COLOR_BITS-1:0]       in_source_color,
  input  wire [cbpw_pkg::COLOR_BITS-1:0]       in_dest_color,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_write_enable,
  output logic [cbpw_pkg::COLOR_BITS-1:0]      out_write_color,
  output logic                                 out_dirty_valid,
  output logic [cbpw_pkg::COORD_BITS-1:0]      out_dirty_left,
  output logic [cbpw_pkg::COORD_BITS-1:0]      out_dirty_top,
  output logic [cbpw_pkg::SPAN_BITS-1:0]       out_dirty_right,
  output logic [cbpw_pkg::SPAN_BITS-1:0]       out_dirty_bottom,
  input  wire                                  cfg_wr_en,
  input  wire [cbpw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [cbpw_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CB = cbpw_pkg::COORD_BITS;
  localparam int SB = cbpw_pkg::SPAN_BITS;

  // Configuration registers
  logic [CB-1:0]                 clip_left_r;
  logic [CB-1:0]                 clip_top_r;
  logic [SB-1:0]                 clip_width_r;
  logic [SB-1:0]                 clip_height_r;
  cbpw_pkg::blend_mode_t         blend_mode_r;
  logic [cbpw_pkg::CHAN_BITS-1:0] const_alpha_r;

  // Input stage
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          s1_opcode_r;
  logic [CB-1:0]                 s1_x_r;
  logic [CB-1:0]                 s1_y_r;
  logic [cbpw_pkg::COLOR_BITS-1:0] s1_src_r;
  logic [cbpw_pkg::COLOR_BITS-1:0] s1_dst_r;

  // Dirty box
  logic          box_valid_r, box_valid_nxt;
  logic [CB-1:0] box_left_r, box_left_nxt;
  logic [CB-1:0] box_top_r, box_top_nxt;
  logic [SB-1:0] box_right_r, box_right_nxt;
  logic [SB-1:0] box_bottom_r, box_bottom_nxt;

  // Result stage
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_we_r;
  logic [cbpw_pkg::COLOR_BITS-1:0] out_color_r;
  logic                            out_dvalid_r;
  logic [CB-1:0]                   out_dleft_r;
  logic [CB-1:0]                   out_dtop_r;
  logic [SB-1:0]                   out_dright_r;
  logic [SB-1:0]                   out_dbottom_r;

  logic                 advance;
  logic                 in_accept;
  logic                 step;
  logic [SB:0]          clip_x_end;
  logic [SB:0]          clip_y_end;
  logic                 in_clip;
  logic                 is_write;
  logic                 do_write;
  logic [SB-1:0]        x_end;
  logic [SB-1:0]        y_end;
  cbpw_pkg::blend_res_t blend_res;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;
  assign step      = s1_valid_r && advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= cbpw_pkg::SPAN_FULL;
      clip_height_r <= cbpw_pkg::SPAN_FULL;
      blend_mode_r  <= cbpw_pkg::MODE_OPAQUE;
      const_alpha_r <= cbpw_pkg::ALPHA_OPAQUE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cbpw_pkg::REG_CLIP_LEFT:      clip_left_r   <= cfg_data[CB-1:0];
        cbpw_pkg::REG_CLIP_TOP:       clip_top_r    <= cfg_data[CB-1:0];
        cbpw_pkg::REG_CLIP_WIDTH:     clip_width_r  <= cfg_data[SB-1:0];
        cbpw_pkg::REG_CLIP_HEIGHT:    clip_height_r <= cfg_data[SB-1:0];
        cbpw_pkg::REG_BLEND_MODE:     blend_mode_r  <= cbpw_pkg::blend_mode_t'(cfg_data[1:0]);
        cbpw_pkg::REG_CONSTANT_ALPHA: const_alpha_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_valid_nxt = in_accept ? 1'b1 : (step ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r <= in_opcode;
      s1_x_r      <= in_pixel_x;
      s1_y_r      <= in_pixel_y;
      s1_src_r    <= in_source_color;
      s1_dst_r    <= in_dest_color;
    end
  end

  // Clip test; the end is kept one bit wider so a full-size span never wraps.
  assign clip_x_end = {2'b00, clip_left_r} + {1'b0, clip_width_r};
  assign clip_y_end = {2'b00, clip_top_r} + {1'b0, clip_height_r};
  assign in_clip = (s1_x_r >= clip_left_r) && (s1_y_r >= clip_top_r) &&
                   ({2'b00, s1_x_r} < clip_x_end) && ({2'b00, s1_y_r} < clip_y_end);

  cbpw_blend u_blend (
    .mode        (blend_mode_r),
    .const_alpha (const_alpha_r),
    .src         (s1_src_r),
    .dst         (s1_dst_r),
    .res         (blend_res)
  );

  assign is_write = (s1_opcode_r == cbpw_pkg::OP_WRITE);
  assign do_write = is_write && in_clip && blend_res.take && (blend_res.color != s1_dst_r);
  assign x_end    = {1'b0, s1_x_r} + {{CB{1'b0}}, 1'b1};
  assign y_end    = {1'b0, s1_y_r} + {{CB{1'b0}}, 1'b1};

  // Dirty box growth
  always_comb begin
    box_valid_nxt  = box_valid_r;
    box_left_nxt   = box_left_r;
    box_top_nxt    = box_top_r;
    box_right_nxt  = box_right_r;
    box_bottom_nxt = box_bottom_r;
    if (!is_write) begin
      box_valid_nxt = 1'b0;
    end else if (do_write) begin
      box_valid_nxt = 1'b1;
      if (!box_valid_r) begin
        box_left_nxt   = s1_x_r;
        box_top_nxt    = s1_y_r;
        box_right_nxt  = x_end;
        box_bottom_nxt = y_end;
      end else begin
        if (s1_x_r < box_left_r) box_left_nxt = s1_x_r;
        if (s1_y_r < box_top_r) box_top_nxt = s1_y_r;
        if (x_end > box_right_r) box_right_nxt = x_end;
        if (y_end > box_bottom_r) box_bottom_nxt = y_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_valid_r  <= 1'b0;
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_right_r  <= '0;
      box_bottom_r <= '0;
    end else if (step) begin
      box_valid_r  <= box_valid_nxt;
      box_left_r   <= box_left_nxt;
      box_top_r    <= box_top_nxt;
      box_right_r  <= box_right_nxt;
      box_bottom_r <= box_bottom_nxt;
    end
  end

  // Result register
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_we_r      <= do_write;
      out_color_r   <= do_write ? blend_res.color : '0;
      out_dvalid_r  <= box_valid_nxt;
      out_dleft_r   <= box_valid_nxt ? box_left_nxt : '0;
      out_dtop_r    <= box_valid_nxt ? box_top_nxt : '0;
      out_dright_r  <= box_valid_nxt ? box_right_nxt : '0;
      out_dbottom_r <= box_valid_nxt ? box_bottom_nxt : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_write_color  = out_color_r;
  assign out_dirty_valid  = out_dvalid_r;
  assign out_dirty_left   = out_dleft_r;
  assign out_dirty_top    = out_dtop_r;
  assign out_dirty_right  = out_dright_r;
  assign out_dirty_bottom = out_dbottom_r;

  // A written pixel always leaves a non-empty dirty box behind it.
  a_write_marks_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_we_r |-> out_dvalid_r)
    else $error("write without dirty box");

  a_empty_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_dvalid_r |->
      out_dleft_r == '0 && out_dtop_r == '0 && out_dright_r == '0 && out_dbottom_r == '0)
    else $error("empty dirty box has nonzero bounds");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dvalid_r |->
      ({1'b0, out_dleft_r} < out_dright_r) && ({1'b0, out_dtop_r} < out_dbottom_r))
    else $error("dirty box bounds out of order");

  a_no_write_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_we_r |-> out_color_r == '0)
    else $error("color present without write");

  a_flush_clears_box: assert property (@(posedge clk) disable iff (!rst_n)
    step && !is_write |=> !box_valid_r)
    else $error("flush left dirty box valid");

endmodule
`default_nettype wire

// ===== src/cbpw_blend.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Blend unit
// Forms the new color of one pixel from source, destination and blend mode.
// ----------------------------------------------------------------------------
module cbpw_blend (
  input  wire cbpw_pkg::blend_mode_t            mode,
  input  wire [cbpw_pkg::CHAN_BITS-1:0]         const_alpha,
  input  wire [cbpw_pkg::COLOR_BITS-1:0]        src,
  input  wire [cbpw_pkg::COLOR_BITS-1:0]        dst,
  output cbpw_pkg::blend_res_t                  res
);

  logic [cbpw_pkg::CHAN_BITS-1:0] alpha;
  logic [cbpw_pkg::CHAN_BITS-1:0] mix_r;
  logic [cbpw_pkg::CHAN_BITS-1:0] mix_g;
  logic [cbpw_pkg::CHAN_BITS-1:0] mix_b;

  assign alpha = (mode == cbpw_pkg::MODE_CONST) ? const_alpha : src[31:24];
  assign mix_r = cbpw_pkg::mix_channel(src[23:16], dst[23:16], alpha);
  assign mix_g = cbpw_pkg::mix_channel(src[15:8], dst[15:8], alpha);
  assign mix_b = cbpw_pkg::mix_channel(src[7:0], dst[7:0], alpha);

  always_comb begin
    case (mode)
      cbpw_pkg::MODE_OPAQUE: begin
        res.take  = 1'b1;
        res.color = src;
      end
      // Constant alpha, source alpha, and the unused code, which acts as source alpha.
      default: begin
        if (alpha == cbpw_pkg::ALPHA_CLEAR) begin
          res.take  = 1'b0;
          res.color = '0;
        end else if (alpha == cbpw_pkg::ALPHA_OPAQUE) begin
          res.take  = 1'b1;
          res.color = {8'h00, src[23:0]};
        end else begin
          res.take  = 1'b1;
          res.color = {8'h00, mix_r, mix_g, mix_b};
        end
      end
    endcase
  end

endmodule
`default_nettype wire
